// ----- design/tec_pkg.sv -----
// Shared types, codes and the transition table of the tilt event confirmation machine.
// Used by tec_step, the top level, tec_checker and the testbench; no dependencies.
package tec_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned CountW  = 16;
  localparam int unsigned EventW  = 3;
  localparam int unsigned ReportW = 2;

  localparam logic [TimeW-1:0]  CONFIRM_RESET_MS = 32'd2500;
  localparam logic [CountW-1:0] COUNT_MAX        = 16'hFFFF;

  // event codes (low two bits; bit 2 set marks an invalid beat)
  localparam logic [1:0] EV_STILL  = 2'd0;
  localparam logic [1:0] EV_RAISED = 2'd1;
  localparam logic [1:0] EV_LOST   = 2'd2;
  localparam logic [1:0] EV_PING   = 2'd3;

  localparam logic [ReportW-1:0] REPORT_CLOSED = 2'd0;
  localparam logic [ReportW-1:0] REPORT_OPENED = 2'd1;
  localparam logic [ReportW-1:0] REPORT_PING   = 2'd3;

  typedef enum logic [7:0] {
    ST_CREATED        = 8'b0000_0001,
    ST_NEW_CLOSURE    = 8'b0000_0010,
    ST_VERIFY_CLOSURE = 8'b0000_0100,
    ST_CONF_CLOSURE   = 8'b0000_1000,
    ST_NEW_OPEN       = 8'b0001_0000,
    ST_VERIFY_OPEN    = 8'b0010_0000,
    ST_CONF_OPEN      = 8'b0100_0000,
    ST_LOST           = 8'b1000_0000
  } tec_state_t;

  typedef struct packed {
    logic       hold;
    tec_state_t state;
  } tec_move_t;

  // Current machine state, handed to the step logic.
  typedef struct packed {
    tec_state_t              state;
    logic [TimeW-1:0]        moved_time;
    logic [TimeW-1:0]        first_open_time;
    logic [CountW-1:0]       opens_seen;
  } tec_ctx_t;

  // Next state plus the report for one beat.
  typedef struct packed {
    tec_ctx_t                ctx;
    logic [ReportW-1:0]      report;
    logic [TimeW-1:0]        since_open;
  } tec_result_t;

  function automatic tec_move_t tec_table(input tec_state_t st, input logic [1:0] ev);
    tec_move_t m;
    m.hold  = 1'b0;
    m.state = st;
    case (st)
      ST_CREATED: begin
        case (ev)
          EV_STILL:  m.state = ST_NEW_CLOSURE;
          EV_RAISED: m.state = ST_NEW_OPEN;
          EV_LOST:   m.state = ST_LOST;
          default:   m.hold  = 1'b1;
        endcase
      end
      ST_NEW_CLOSURE: begin
        case (ev)
          EV_RAISED: m.state = ST_VERIFY_OPEN;
          EV_LOST:   m.state = ST_LOST;
          default:   m.state = ST_VERIFY_CLOSURE;
        endcase
      end
      ST_VERIFY_CLOSURE: begin
        case (ev)
          EV_RAISED: m.state = ST_NEW_OPEN;
          EV_LOST:   m.state = ST_LOST;
          default:   m.state = ST_VERIFY_CLOSURE;
        endcase
      end
      ST_CONF_CLOSURE: begin
        case (ev)
          EV_RAISED: m.state = ST_NEW_OPEN;
          EV_LOST:   m.state = ST_LOST;
          default:   m.hold  = 1'b1;
        endcase
      end
      ST_NEW_OPEN, ST_VERIFY_OPEN: begin
        case (ev)
          EV_STILL:  m.state = ST_NEW_CLOSURE;
          EV_LOST:   m.state = ST_LOST;
          default:   m.state = ST_VERIFY_OPEN;
        endcase
      end
      ST_CONF_OPEN: begin
        case (ev)
          EV_STILL:  m.state = ST_NEW_CLOSURE;
          EV_RAISED: m.state = ST_CONF_OPEN;
          EV_LOST:   m.state = ST_LOST;
          default:   m.hold  = 1'b1;
        endcase
      end
      ST_LOST: begin
        case (ev)
          EV_STILL:  m.state = ST_NEW_CLOSURE;
          EV_RAISED: m.state = ST_NEW_OPEN;
          default:   m.hold  = 1'b1;
        endcase
      end
      default: m.hold = 1'b1;
    endcase
    return m;
  endfunction

endpackage

// ----- design/tec_step.sv -----
// Combinational step of the tilt event machine: table lookup, elapsed check, count update.
// Depends on tec_pkg.
module tec_step (
  input  tec_pkg::tec_ctx_t              cur,
  input  logic [1:0]                     ev,
  input  logic [tec_pkg::TimeW-1:0]      now_ms,
  input  logic [tec_pkg::TimeW-1:0]      confirm_ms,
  output tec_pkg::tec_result_t           res
);

  tec_pkg::tec_move_t          move;
  logic [tec_pkg::TimeW-1:0]   elapsed;
  logic                        settled;

  assign move    = tec_pkg::tec_table(cur.state, ev);
  assign elapsed = now_ms - cur.moved_time;
  assign settled = (elapsed >= confirm_ms);

  always_comb begin
    res.ctx        = cur;
    res.report     = tec_pkg::REPORT_PING;
    res.since_open = '0;
    if (!move.hold) begin
      res.ctx.state = move.state;
      case (move.state)
        tec_pkg::ST_NEW_CLOSURE, tec_pkg::ST_NEW_OPEN: begin
          res.ctx.moved_time = now_ms;
        end
        tec_pkg::ST_VERIFY_CLOSURE: begin
          if (settled) begin
            res.ctx.state = tec_pkg::ST_CONF_CLOSURE;
            res.report    = tec_pkg::REPORT_CLOSED;
          end
        end
        tec_pkg::ST_VERIFY_OPEN: begin
          if (settled) begin
            res.ctx.state = tec_pkg::ST_CONF_OPEN;
            res.report    = tec_pkg::REPORT_OPENED;
            if (cur.opens_seen == '0) begin
              res.ctx.first_open_time = now_ms;
            end
            if (cur.opens_seen != tec_pkg::COUNT_MAX) begin
              res.ctx.opens_seen = cur.opens_seen + 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
    // first open on this beat sets first_open_time to now, giving zero
    if (res.ctx.opens_seen != '0) begin
      res.since_open = now_ms - res.ctx.first_open_time;
    end
  end

endmodule

// ----- design/tilt_event_confirmation_fsm_top.sv -----
// Tilt event confirmation machine: top level with input register, step logic, result register.
// Depends on tec_pkg and tec_step.
// A beat passes the input register, then the result register that drives the out_ ports.
// One beat per cycle unless stalled; the machine state feeds back through one step of logic.
// Invalid status beats (codes 4 to 7) pass through the input register and yield no report.
// Reset (rst_n low, synchronous): state to created, times and count to zero, threshold 2500 ms.
module tilt_event_confirmation_fsm_top (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_wr_en,
  input  logic [tec_pkg::TimeW-1:0]         cfg_wr_data,
  // event beats
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [tec_pkg::EventW-1:0]        in_event_status,
  input  logic [tec_pkg::TimeW-1:0]         in_now_ms,
  // report beats
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [tec_pkg::ReportW-1:0]       out_report_status,
  output logic [tec_pkg::TimeW-1:0]         out_since_first_open_ms,
  output logic [tec_pkg::CountW-1:0]        out_open_count
);

  // threshold register
  logic [tec_pkg::TimeW-1:0]   confirm_r;

  // input register
  logic                        s1_valid_r, s1_valid_nxt;
  logic [tec_pkg::EventW-1:0]  s1_ev_r;
  logic [tec_pkg::TimeW-1:0]   s1_now_r;

  // machine state
  tec_pkg::tec_ctx_t           ctx_r;
  tec_pkg::tec_result_t        step_res;

  // result register
  logic                        out_valid_r, out_valid_nxt;
  logic [tec_pkg::ReportW-1:0] out_report_r;
  logic [tec_pkg::TimeW-1:0]   out_since_r;
  logic [tec_pkg::CountW-1:0]  out_count_r;

  logic in_take, ev_ok, out_free, s1_go, commit;

  // Valid events are codes 0..3; bit 2 flags anything else.
  assign ev_ok    = !s1_ev_r[2];
  assign out_free = !out_valid_r || !out_stall;
  // An invalid beat never needs the result register, so drop it at once.
  assign s1_go    = s1_valid_r && (out_free || !ev_ok);
  assign commit   = s1_go && ev_ok;
  assign in_stall = s1_valid_r && !s1_go;
  assign in_take  = in_valid && !in_stall;

  assign s1_valid_nxt  = in_take || (s1_valid_r && !s1_go);
  assign out_valid_nxt = commit || (out_valid_r && out_stall);

  tec_step u_step (
    .cur        (ctx_r),
    .ev         (s1_ev_r[1:0]),
    .now_ms     (s1_now_r),
    .confirm_ms (confirm_r),
    .res        (step_res)
  );

  // control and machine state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      confirm_r             <= tec_pkg::CONFIRM_RESET_MS;
      s1_valid_r            <= 1'b0;
      out_valid_r           <= 1'b0;
      ctx_r.state           <= tec_pkg::ST_CREATED;
      ctx_r.moved_time      <= '0;
      ctx_r.first_open_time <= '0;
      ctx_r.opens_seen      <= '0;
    end else begin
      if (cfg_wr_en) begin
        confirm_r <= cfg_wr_data;
      end
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      // advance the machine only when the report has a place to go
      if (commit) begin
        ctx_r <= step_res.ctx;
      end
    end
  end

  // payload: load the input register on accept, hold otherwise
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_ev_r  <= in_event_status;
      s1_now_r <= in_now_ms;
    end
  end

  // payload: load the result register on commit, hold while stalled
  always_ff @(posedge clk) begin
    if (commit) begin
      out_report_r <= step_res.report;
      out_since_r  <= step_res.since_open;
      out_count_r  <= step_res.ctx.opens_seen;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_report_status       = out_report_r;
  assign out_since_first_open_ms = out_since_r;
  assign out_open_count          = out_count_r;

endmodule

// ----- design/tec_checker.sv -----
// Port-level checks for the tilt event confirmation machine, bound to the top level.
// Depends on tec_pkg and tilt_event_confirmation_fsm_top.
module tec_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [tec_pkg::ReportW-1:0]       out_report_status,
  input logic [tec_pkg::TimeW-1:0]         out_since_first_open_ms,
  input logic [tec_pkg::CountW-1:0]        out_open_count
);

  // no report beat right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("report beat present after reset");

  // a stalled report beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_report_status)
      && $stable(out_since_first_open_ms) && $stable(out_open_count))
    else $error("stalled report beat changed");

  // status code 2 is never reported
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_report_status != 2'd2)
    else $error("reserved report status");

  // never opened means no time since first open
  a_since_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_open_count == '0 |-> out_since_first_open_ms == '0)
    else $error("time since open without any opening");

  // a confirmed opening counts
  a_open_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_report_status == tec_pkg::REPORT_OPENED |-> out_open_count != '0)
    else $error("opening confirmed with zero count");

endmodule

bind tilt_event_confirmation_fsm_top tec_checker u_tec_checker (
  .clk                     (clk),
  .rst_n                   (rst_n),
  .out_valid               (out_valid),
  .out_stall               (out_stall),
  .out_report_status       (out_report_status),
  .out_since_first_open_ms (out_since_first_open_ms),
  .out_open_count          (out_open_count)
);

// ----- tb/testbench.sv -----
// Self-checking testbench for the tilt event confirmation machine, with a built-in predictor.
// Depends on tec_pkg and tilt_event_confirmation_fsm_top; reads no files.
// Tasks run reset defaults, threshold extremes, backpressure and random phases.
module testbench;

  localparam int unsigned TimeW   = tec_pkg::TimeW;
  localparam int unsigned CountW  = tec_pkg::CountW;
  localparam int unsigned EventW  = tec_pkg::EventW;
  localparam int unsigned ReportW = tec_pkg::ReportW;

  // Stop the run after this many cycles with no beat accepted on either channel.
  localparam int IDLE_LIMIT = 5000;
  // Allow for beats still inside the block, including invalid ones that never report.
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASE_ITEMS = 296;
  localparam logic [EventW-1:0] BAD_EVENT_FIRST = 3'd4;

  typedef struct packed {
    logic [ReportW-1:0] status;
    logic [TimeW-1:0]   since_open;
    logic [CountW-1:0]  count;
  } lid_report_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_wr_en;
  logic [TimeW-1:0]    cfg_wr_data;
  logic                in_valid;
  logic                in_stall;
  logic [EventW-1:0]   in_event_status;
  logic [TimeW-1:0]    in_now_ms;
  logic                out_valid;
  logic                out_stall;
  logic [ReportW-1:0]  out_report_status;
  logic [TimeW-1:0]    out_since_first_open_ms;
  logic [CountW-1:0]   out_open_count;

  // Predictor state: a mirror of the machine and its threshold register.
  tec_pkg::tec_state_t lid_state;
  logic [TimeW-1:0]    moved_at;
  logic [TimeW-1:0]    first_open_at;
  logic [CountW-1:0]   opens_q;
  logic [TimeW-1:0]    confirm_ms;
  lid_report_t         expected_reports[$];

  int errors;
  int idle_cycles;
  int stall_left;
  int hold_off_left;
  bit sender_idles;
  bit receiver_idles;

  tilt_event_confirmation_fsm_top uut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cfg_wr_en               (cfg_wr_en),
    .cfg_wr_data             (cfg_wr_data),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_event_status         (in_event_status),
    .in_now_ms               (in_now_ms),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_report_status       (out_report_status),
    .out_since_first_open_ms (out_since_first_open_ms),
    .out_open_count          (out_open_count)
  );

  always #5 clk = ~clk;

  function automatic logic [EventW-1:0] ev3(input logic [1:0] code);
    return {1'b0, code};
  endfunction

  // Most gaps are zero or short; a few are long.
  function automatic int pick_gap(input bit enabled);
    int r;
    r = $urandom_range(0, 99);
    if (!enabled || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Advance the predicted machine by one event and queue the report it causes.
  task automatic predict_lid_report(input logic [EventW-1:0] ev, input logic [TimeW-1:0] now);
    tec_pkg::tec_state_t nxt;
    logic                held;
    logic [TimeW-1:0]    elapsed;
    lid_report_t         rep;
    // Drop invalid codes: no state change, no report.
    if (ev[2]) return;
    held = 1'b0;
    nxt  = lid_state;
    case (lid_state)
      tec_pkg::ST_CREATED: begin
        case (ev[1:0])
          tec_pkg::EV_STILL:  nxt = tec_pkg::ST_NEW_CLOSURE;
          tec_pkg::EV_RAISED: nxt = tec_pkg::ST_NEW_OPEN;
          tec_pkg::EV_LOST:   nxt = tec_pkg::ST_LOST;
          default:            held = 1'b1;
        endcase
      end
      tec_pkg::ST_NEW_CLOSURE: begin
        case (ev[1:0])
          tec_pkg::EV_RAISED: nxt = tec_pkg::ST_VERIFY_OPEN;
          tec_pkg::EV_LOST:   nxt = tec_pkg::ST_LOST;
          default:            nxt = tec_pkg::ST_VERIFY_CLOSURE;
        endcase
      end
      tec_pkg::ST_VERIFY_CLOSURE: begin
        case (ev[1:0])
          tec_pkg::EV_RAISED: nxt = tec_pkg::ST_NEW_OPEN;
          tec_pkg::EV_LOST:   nxt = tec_pkg::ST_LOST;
          default:            nxt = tec_pkg::ST_VERIFY_CLOSURE;
        endcase
      end
      tec_pkg::ST_CONF_CLOSURE: begin
        case (ev[1:0])
          tec_pkg::EV_RAISED: nxt = tec_pkg::ST_NEW_OPEN;
          tec_pkg::EV_LOST:   nxt = tec_pkg::ST_LOST;
          default:            held = 1'b1;
        endcase
      end
      tec_pkg::ST_NEW_OPEN, tec_pkg::ST_VERIFY_OPEN: begin
        case (ev[1:0])
          tec_pkg::EV_STILL:  nxt = tec_pkg::ST_NEW_CLOSURE;
          tec_pkg::EV_LOST:   nxt = tec_pkg::ST_LOST;
          default:            nxt = tec_pkg::ST_VERIFY_OPEN;
        endcase
      end
      tec_pkg::ST_CONF_OPEN: begin
        case (ev[1:0])
          tec_pkg::EV_STILL:  nxt = tec_pkg::ST_NEW_CLOSURE;
          tec_pkg::EV_RAISED: nxt = tec_pkg::ST_CONF_OPEN;
          tec_pkg::EV_LOST:   nxt = tec_pkg::ST_LOST;
          default:            held = 1'b1;
        endcase
      end
      default: begin
        // signal lost: only a still or raised lid leaves it
        case (ev[1:0])
          tec_pkg::EV_STILL:  nxt = tec_pkg::ST_NEW_CLOSURE;
          tec_pkg::EV_RAISED: nxt = tec_pkg::ST_NEW_OPEN;
          default:            held = 1'b1;
        endcase
      end
    endcase

    rep.status = tec_pkg::REPORT_PING;
    elapsed = now - moved_at;
    if (!held) begin
      lid_state = nxt;
      case (nxt)
        tec_pkg::ST_NEW_CLOSURE, tec_pkg::ST_NEW_OPEN: moved_at = now;
        tec_pkg::ST_VERIFY_CLOSURE: begin
          if (elapsed >= confirm_ms) begin
            lid_state  = tec_pkg::ST_CONF_CLOSURE;
            rep.status = tec_pkg::REPORT_CLOSED;
          end
        end
        tec_pkg::ST_VERIFY_OPEN: begin
          if (elapsed >= confirm_ms) begin
            lid_state  = tec_pkg::ST_CONF_OPEN;
            rep.status = tec_pkg::REPORT_OPENED;
            // Record only the very first confirmed opening; saturate the count.
            if (opens_q == '0) first_open_at = now;
            if (opens_q != tec_pkg::COUNT_MAX) opens_q = opens_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
    rep.since_open = (opens_q != '0) ? now - first_open_at : '0;
    rep.count      = opens_q;
    expected_reports.push_back(rep);
  endtask

  // Offer one event beat, hold it until accepted, then predict its report.
  // Valid stays high on return so that a following beat goes out back to back.
  task automatic send_beat(input logic [EventW-1:0] ev, input logic [TimeW-1:0] now);
    int gap;
    gap = pick_gap(sender_idles);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_event_status <= ev;
    in_now_ms       <= now;
    do @(posedge clk); while (in_stall !== 1'b0);
    predict_lid_report(ev, now);
  endtask

  // Drop valid, wait for every expected report, then let in-flight beats settle.
  task automatic drain;
    in_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Call only while the block is idle.
  task automatic write_threshold(input logic [TimeW-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    confirm_ms = value;
  endtask

  task automatic check_field(input string name, input logic [TimeW-1:0] want,
                             input logic [TimeW-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Walk many entries of the table with the reset threshold of 2500 ms, plus invalid codes.
  task automatic test_reset_defaults;
    send_beat(ev3(tec_pkg::EV_PING), 32'd0);           // ignored entry in the created state
    send_beat(BAD_EVENT_FIRST, 32'd50);
    send_beat(ev3(tec_pkg::EV_STILL), 32'd100);
    send_beat(ev3(tec_pkg::EV_STILL), 32'd2599);       // one ms short of the threshold
    send_beat(ev3(tec_pkg::EV_STILL), 32'd2600);       // exactly at it: closure confirmed
    send_beat(ev3(tec_pkg::EV_STILL), 32'd2700);       // ignored in confirmed closure
    send_beat(ev3(tec_pkg::EV_PING), 32'd2800);
    send_beat(ev3(tec_pkg::EV_RAISED), 32'd3000);
    send_beat(ev3(tec_pkg::EV_PING), 32'd5499);
    send_beat(ev3(tec_pkg::EV_RAISED), 32'd5500);      // first opening confirmed
    send_beat(ev3(tec_pkg::EV_RAISED), 32'd6000);
    send_beat(ev3(tec_pkg::EV_PING), 32'd6100);
    send_beat(ev3(tec_pkg::EV_LOST), 32'd7000);
    send_beat(ev3(tec_pkg::EV_LOST), 32'd7100);
    send_beat(ev3(tec_pkg::EV_PING), 32'd7200);
    for (int k = 0; k < 4; k++)
      send_beat(BAD_EVENT_FIRST + EventW'(k), 32'hFFFF_FFFF);
    send_beat(ev3(tec_pkg::EV_RAISED), 32'd8000);
    send_beat(ev3(tec_pkg::EV_STILL), 32'd9000);
    send_beat(ev3(tec_pkg::EV_RAISED), 32'd9500);      // new closure straight into verifying open
    send_beat(ev3(tec_pkg::EV_RAISED), 32'hFFFF_FFFF);
    drain();
  endtask

  // Threshold of zero confirms at once; all ones needs a full wrap of the clock.
  task automatic test_threshold_extremes;
    write_threshold('0);
    send_beat(ev3(tec_pkg::EV_LOST), 32'd0);
    send_beat(ev3(tec_pkg::EV_RAISED), 32'd0);
    send_beat(ev3(tec_pkg::EV_PING), 32'd0);
    send_beat(ev3(tec_pkg::EV_STILL), 32'd1);
    send_beat(ev3(tec_pkg::EV_STILL), 32'd1);
    drain();
    write_threshold('1);
    send_beat(ev3(tec_pkg::EV_LOST), 32'd5);
    send_beat(ev3(tec_pkg::EV_RAISED), 32'd1);
    send_beat(ev3(tec_pkg::EV_RAISED), 32'd0);         // elapsed wraps to all ones
    send_beat(ev3(tec_pkg::EV_STILL), 32'hFFFF_FFFF);
    send_beat(ev3(tec_pkg::EV_STILL), 32'hFFFF_FFFE);
    drain();
    write_threshold(tec_pkg::CONFIRM_RESET_MS);
  endtask

  // Hold the receiver off for a long stretch while the sender keeps pushing beats.
  task automatic test_backpressure;
    logic [TimeW-1:0] now;
    now = 32'd20000;
    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    hold_off_left  = 300;
    for (int i = 0; i < 40; i++) begin
      now = now + $urandom_range(0, 1500);
      send_beat(EventW'($urandom_range(0, 3)), now);
    end
    drain();
  endtask

  // Random phases: runs of one lid condition with pings, mixed with noise,
  // under a different threshold in each phase.
  task automatic test_random_phases;
    logic [TimeW-1:0] thr;
    logic [TimeW-1:0] now;
    logic [1:0]       cond;
    int               run_left;
    int               r;
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: thr = $urandom_range(1, 50);
        1: thr = '0;
        2: thr = $urandom_range(100, 5000);
        3: thr = '1;
        4: thr = $urandom();
        default: thr = tec_pkg::CONFIRM_RESET_MS;
      endcase
      write_threshold(thr);
      // keep the first phase free of idling on both sides
      sender_idles   = (p != 0);
      receiver_idles = (p != 0);
      now      = $urandom();
      run_left = 0;
      cond     = tec_pkg::EV_STILL;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        r = $urandom_range(0, 99);
        if (thr > 32'h0100_0000) now = now + $urandom();
        else now = now + $urandom_range(0, thr / 2 + 2);
        if (r < 8) begin
          if (r < 4) now = $urandom();
          send_beat(EventW'($urandom_range(0, 7)), now);
        end else begin
          // land right on the threshold or one ms short of it
          if (r < 14) now = moved_at + confirm_ms - $urandom_range(0, 1);
          if (run_left == 0) begin
            r = $urandom_range(0, 99);
            cond = (r < 45) ? tec_pkg::EV_STILL : (r < 90) ? tec_pkg::EV_RAISED
                                                          : tec_pkg::EV_LOST;
            run_left = $urandom_range(1, 8);
          end
          run_left--;
          send_beat(($urandom_range(0, 99) < 15) ? ev3(tec_pkg::EV_PING) : ev3(cond), now);
        end
      end
      drain();
    end
  endtask

  // Receiver: hold-off requests first, then random short and long stalls.
  always @(posedge clk) begin
    if (hold_off_left > 0) begin
      hold_off_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (receiver_idles && $urandom_range(0, 99) < 20) begin
      stall_left = ($urandom_range(0, 99) < 95) ? $urandom_range(0, 3) : $urandom_range(20, 60);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare each accepted report beat with the oldest expectation.
  always @(posedge clk) begin
    lid_report_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_reports.size() == 0) begin
        errors++;
        $display("%0t: report beat with nothing expected, status %0d", $time,
                 out_report_status);
      end else begin
        want = expected_reports.pop_front();
        check_field("report_status", TimeW'(want.status), TimeW'(out_report_status));
        check_field("since_first_open_ms", want.since_open, out_since_first_open_ms);
        check_field("open_count", TimeW'(want.count), TimeW'(out_open_count));
      end
    end
  end

  // Watchdog: restart on any accepted beat, end the run when traffic stops.
  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    clk             = 1'b0;
    rst_n           = 1'b0;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = '0;
    in_valid        = 1'b0;
    in_event_status = '0;
    in_now_ms       = '0;
    out_stall       = 1'b0;
    errors          = 0;
    idle_cycles     = 0;
    stall_left      = 0;
    hold_off_left   = 0;
    sender_idles    = 1'b1;
    receiver_idles  = 1'b1;
    lid_state       = tec_pkg::ST_CREATED;
    moved_at        = '0;
    first_open_at   = '0;
    opens_q         = '0;
    confirm_ms      = tec_pkg::CONFIRM_RESET_MS;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_threshold_extremes();
    test_backpressure();
    test_random_phases();

    if (errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// ----- tilt_event_confirmation_fsm_top.f -----
design/tec_pkg.sv
design/tec_step.sv
design/tilt_event_confirmation_fsm_top.sv
design/tec_checker.sv
tb/testbench.sv
